[design/udmu_pkg.sv]
// ----------------------------------------------------------------------------
// udmu_pkg
// Shared opcodes, widths and the pipeline word carried along the divider chain.
// ----------------------------------------------------------------------------
package udmu_pkg;

  localparam int OpW      = 3;
  localparam int AW       = 32;
  localparam int BW       = 24;
  localparam int DivSteps = AW;

  localparam logic [OpW-1:0] OP_DIV8    = 3'd0;
  localparam logic [OpW-1:0] OP_DIV16   = 3'd1;
  localparam logic [OpW-1:0] OP_DIV24   = 3'd2;
  localparam logic [OpW-1:0] OP_DIV32   = 3'd3;
  localparam logic [OpW-1:0] OP_MUL8    = 3'd4;
  localparam logic [OpW-1:0] OP_MUL16   = 3'd5;

  // one word in flight: quo starts as the dividend (or holds the product)
  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          dz;
    logic [OpW-1:0] op;
    logic [BW-1:0] divisor;
    logic [BW-1:0] rem;
    logic [AW-1:0] quo;
  } udmu_word_t;

endpackage

[design/udmu_prep.sv]
// ----------------------------------------------------------------------------
// udmu_prep
// Input register: masks operands to the mode width, flags a zero divisor and
// forms the product for multiply modes.
// ----------------------------------------------------------------------------
module udmu_prep (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     load,
  input  logic [udmu_pkg::OpW-1:0] opcode,
  input  logic [udmu_pkg::AW-1:0]  operand_a,
  input  logic [udmu_pkg::BW-1:0]  operand_b,
  output udmu_pkg::udmu_word_t     word_out
);
  import udmu_pkg::*;

  udmu_word_t word_next;
  logic [15:0] mul_a;
  logic [15:0] mul_b;

  always_comb begin
    mul_a = (opcode == OP_MUL8) ? {8'd0, operand_a[7:0]} : operand_a[15:0];
    mul_b = (opcode == OP_MUL8) ? {8'd0, operand_b[7:0]} : operand_b[15:0];
    word_next         = '0;
    word_next.valid   = load;
    word_next.op      = opcode;
    unique case (opcode)
      OP_DIV8: begin
        word_next.is_div  = 1'b1;
        word_next.quo     = {24'd0, operand_a[7:0]};
        word_next.divisor = {16'd0, operand_b[7:0]};
      end
      OP_DIV16: begin
        word_next.is_div  = 1'b1;
        word_next.quo     = {16'd0, operand_a[15:0]};
        word_next.divisor = {8'd0, operand_b[15:0]};
      end
      OP_DIV24: begin
        word_next.is_div  = 1'b1;
        word_next.quo     = {8'd0, operand_a[23:0]};
        word_next.divisor = operand_b;
      end
      OP_DIV32: begin
        word_next.is_div  = 1'b1;
        word_next.quo     = operand_a;
        word_next.divisor = operand_b;
      end
      OP_MUL8, OP_MUL16: begin
        word_next.quo = mul_a * mul_b;
      end
      default: begin
      end
    endcase
    word_next.dz = word_next.is_div && (word_next.divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else if (en) begin
      word_out <= word_next;
    end
  end

endmodule

[design/udmu_cell.sv]
// ----------------------------------------------------------------------------
// udmu_cell
// One restoring-division step: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts in a quotient bit.
// ----------------------------------------------------------------------------
module udmu_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  udmu_pkg::udmu_word_t word_in,
  output udmu_pkg::udmu_word_t word_out
);
  import udmu_pkg::*;

  udmu_word_t   word_next;
  logic [BW:0]  rem_shift;
  logic [BW:0]  rem_diff;
  logic         take;

  always_comb begin
    rem_shift = {word_in.rem, word_in.quo[AW-1]};
    rem_diff  = rem_shift - {1'b0, word_in.divisor};
    // zero divisor never subtracts, so the remainder ends up as the dividend's low BW bits
    take      = word_in.is_div && !word_in.dz && (rem_shift >= {1'b0, word_in.divisor});
    word_next = word_in;
    if (word_in.is_div) begin
      word_next.rem = take ? rem_diff[BW-1:0] : rem_shift[BW-1:0];
      word_next.quo = {word_in.quo[AW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else if (en) begin
      word_out <= word_next;
    end
  end

endmodule

[design/unsigned_divide_multiply_unit.sv]
// ----------------------------------------------------------------------------
// unsigned_divide_multiply_unit
// Pipelined unsigned divider and multiplier with a valid/stall handshake.
//
// Usage: present opcode, operand_a and operand_b with in_valid; the word is
// taken at a clock edge where in_valid is high and in_stall is low. Each word
// gives exactly one result word on main_result, remainder and divide_by_zero,
// taken where out_valid is high and out_stall is low. Results leave in input
// order.
// Path: the input register loads at the accepting edge, then 32 division
// cells and one result register (or the skid register on a stall) follow.
// Multiply words ride the same chain.
// Throughput: one word per cycle while in_stall is low; each cell does one
// quotient bit and hands its partial remainder on whenever the chain advances.
// Stall: a two-entry output (result register plus skid register) absorbs the
// word in flight; in_stall rises only when the skid register is full, and the
// whole chain then holds until the receiver takes a word.
// Reset: rst clears all valid flags; the pipeline is empty afterward.
// ----------------------------------------------------------------------------
module unsigned_divide_multiply_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [udmu_pkg::OpW-1:0] opcode,
  input  logic [udmu_pkg::AW-1:0]  operand_a,
  input  logic [udmu_pkg::BW-1:0]  operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [udmu_pkg::AW-1:0]  main_result,
  output logic [udmu_pkg::BW-1:0]  remainder,
  output logic                     divide_by_zero
);
  import udmu_pkg::*;

  udmu_word_t       chain [0:DivSteps];
  logic             advance;
  logic             skid_valid;
  logic [AW-1:0]    skid_result;
  logic [BW-1:0]    skid_rem;
  logic             skid_dz;
  logic [AW-1:0]    fin_result;
  logic             out_free;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  udmu_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .load      (in_valid),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .word_out  (chain[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    udmu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

  // zero divisor gives an all-ones quotient at the mode width
  always_comb begin
    fin_result = chain[DivSteps].quo;
    if (chain[DivSteps].dz) begin
      unique case (chain[DivSteps].op)
        OP_DIV8:  fin_result = 32'h0000_00FF;
        OP_DIV16: fin_result = 32'h0000_FFFF;
        OP_DIV24: fin_result = 32'h00FF_FFFF;
        default:  fin_result = 32'hFFFF_FFFF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid      <= 1'b1;
        main_result    <= skid_result;
        remainder      <= skid_rem;
        divide_by_zero <= skid_dz;
        skid_valid     <= 1'b0;
      end else begin
        out_valid      <= chain[DivSteps].valid;
        main_result    <= fin_result;
        remainder      <= chain[DivSteps].rem;
        divide_by_zero <= chain[DivSteps].dz;
      end
    end else if (advance && chain[DivSteps].valid) begin
      skid_valid  <= 1'b1;
      skid_result <= fin_result;
      skid_rem    <= chain[DivSteps].rem;
      skid_dz     <= chain[DivSteps].dz;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output not empty after reset");

  a_dz_all_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (main_result[7:0] == 8'hFF))
    else $error("zero divisor without all-ones quotient");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (chain[DivSteps].valid && chain[DivSteps].is_div && !chain[DivSteps].dz)
      |-> (chain[DivSteps].rem < chain[DivSteps].divisor))
    else $error("remainder not below divisor");

endmodule
